// File: sv/twm_pkg.sv
// Shared types, constants and helper functions of the windowed throughput meter.
`timescale 1ns / 1ps
`default_nettype none
package twm_pkg;
  localparam int TIME_W = 63;
  localparam int CNT_W  = 32;
  localparam int RATE_W = 48;
  localparam int CFG_W  = 32;
  localparam int ADDR_W = 3;
  localparam int MUL_AW = 33;
  localparam int MUL_BW = 30;
  localparam int MUL_PW = 63;

  localparam logic [MUL_BW-1:0] NS_PER_MS = 30'd1000000;
  localparam logic [MUL_BW-1:0] NS_PER_S  = 30'd1000000000;
  localparam int unsigned MIN_KEPT = 2;

  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
  localparam logic [CFG_W-1:0] RST_PRINT_INTERVAL = 32'd1000;
  localparam logic [CFG_W-1:0] RST_WINDOW         = 32'd10000;

  // Register index taken from the word address bit.
  localparam logic REG_PRINT_INTERVAL = 1'b0;
  localparam logic REG_WINDOW         = 1'b1;

  typedef logic [TIME_W-1:0] time_t;

  function automatic time_t span_of(input time_t older, input time_t newer);
    span_of = (newer >= older) ? (newer - older) : '0;
  endfunction
endpackage
`default_nettype wire

// File: sv/twm_ifs.sv
// Handshake channel interfaces for report beats and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface twm_in_if;
  logic                            valid;
  logic                            ready;
  logic [twm_pkg::TIME_W-1:0]      time_ns;
  logic [twm_pkg::CNT_W-1:0]       work_count;
  logic [1:0]                      device_index;
  modport source(output valid, time_ns, work_count, device_index, input ready);
  modport sink(input valid, time_ns, work_count, device_index, output ready);
endinterface

interface twm_out_if;
  logic                            valid;
  logic                            ready;
  logic [twm_pkg::RATE_W-1:0]      total_rate;
  logic [twm_pkg::RATE_W-1:0]      device_rate;
  logic                            print_due;
  logic                            ring_overflow;
  modport source(output valid, total_rate, device_rate, print_due, ring_overflow,
                 input ready);
  modport sink(input valid, total_rate, device_rate, print_due, ring_overflow,
               output ready);
endinterface
`default_nettype wire

// File: sv/twm_rate_div.sv
// Bit-serial restoring divider that turns a scaled sum and a span into a saturated rate.
`timescale 1ns / 1ps
`default_nettype none
module twm_rate_div
  import twm_pkg::*;
#(
  parameter int NUMW = 68
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [NUMW-1:0]   num,
  input  wire time_t             den,
  output logic                   done,
  output logic [RATE_W-1:0]      rate
);
  localparam int CW = $clog2(NUMW + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [NUMW-1:0]   nsh_r, nsh_nxt;
  logic [NUMW-1:0]   q_r, q_nxt;
  time_t             den_r, den_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic [TIME_W:0]   rem2;
  logic              ge;

  assign rem2 = {rem_r, nsh_r[NUMW-1]};
  assign ge   = rem2 >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    nsh_nxt  = nsh_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    rate_nxt = rate_r;
    if (start) begin
      den_nxt = den;
      nsh_nxt = num;
      rem_nxt = '0;
      q_nxt   = '0;
      cnt_nxt = CW'(NUMW);
      if (den == '0) begin
        rate_nxt = '0;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = ge ? TIME_W'(rem2 - {1'b0, den_r}) : rem2[TIME_W-1:0];
      q_nxt   = {q_r[NUMW-2:0], ge};
      nsh_nxt = {nsh_r[NUMW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        rate_nxt = (|q_nxt[NUMW-1:RATE_W]) ? RATE_MAX : q_nxt[RATE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    nsh_r  <= nsh_nxt;
    q_r    <= q_nxt;
    den_r  <= den_nxt;
    rate_r <= rate_nxt;
  end

  assign done = done_r;
  assign rate = rate_r;
endmodule
`default_nettype wire

// File: sv/windowed_throughput_meter_core.sv
// Top level of the windowed throughput meter: sequencer, rings, shared multiplier.
//
//   Port group  | Direction | Contents
//   in_beat     | sink      | time_ns, work_count, device_index
//   out_beat    | source    | total_rate, device_rate, print_due, ring_overflow
//   APB         | slave     | print_interval_ms at 0x0, window_ms at 0x4
//
// The bit-serial divider runs once per ring and shifts through all NUM bits of the
// numerator, where NUM is the numerator width (68 by default); it skips these steps
// and gives a rate of zero when the span is zero.
// Each dropped sample is read back through the ring memory read port, and a full
// ring first drops its oldest sample in a step of its own. Reset is synchronous and empties all rings.
// A new report is taken only when the sequencer is idle; a waiting result
// does not block the next report until that report's result is ready.
`timescale 1ns / 1ps
`default_nettype none
module windowed_throughput_meter_core
  import twm_pkg::*;
#(
  parameter int WINDOW_DEPTH = 64,
  parameter int NUM_DEVICES  = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  twm_in_if.sink                   in_beat,
  twm_out_if.source                out_beat,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [CFG_W-1:0]    pwdata,
  output logic [CFG_W-1:0]         prdata,
  output logic                     pready
);
  localparam int HW   = $clog2(WINDOW_DEPTH);
  localparam int FW   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUMW = CNT_W + $clog2(WINDOW_DEPTH);
  localparam int NUMW = SUMW + MUL_BW;
  localparam int DEVW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int DAW  = $clog2(NUM_DEVICES * WINDOW_DEPTH);
  localparam int MW   = TIME_W + CNT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_THR1 = 4'd1;
  localparam logic [3:0] S_THR2 = 4'd2;
  localparam logic [3:0] S_DUE  = 4'd3;
  localparam logic [3:0] S_LOAD = 4'd4;
  localparam logic [3:0] S_CHKF = 4'd5;
  localparam logic [3:0] S_OVF  = 4'd6;
  localparam logic [3:0] S_WRT  = 4'd7;
  localparam logic [3:0] S_PREQ = 4'd8;
  localparam logic [3:0] S_PCHK = 4'd9;
  localparam logic [3:0] S_MLO  = 4'd10;
  localparam logic [3:0] S_MHI  = 4'd11;
  localparam logic [3:0] S_DST  = 4'd12;
  localparam logic [3:0] S_DIV  = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  logic [3:0]        state_r;
  logic [CFG_W-1:0]  print_ms_r, window_ms_r;
  time_t             t_r, last_print_r, wthr_r, pthr_r, span_r;
  logic [CNT_W-1:0]  c_r;
  logic [1:0]        d_r;
  logic              due_r, ovf_r, sel_r;

  logic [HW-1:0]     tot_head_r;
  logic [FW-1:0]     tot_fill_r;
  logic [SUMW-1:0]   tot_sum_r;
  logic [HW-1:0]     dev_head_r [NUM_DEVICES];
  logic [FW-1:0]     dev_fill_r [NUM_DEVICES];
  logic [SUMW-1:0]   dev_sum_r  [NUM_DEVICES];
  logic [NUM_DEVICES-1:0] dev_vld_r;

  logic [HW-1:0]     wk_head_r;
  logic [FW-1:0]     wk_fill_r;
  logic [SUMW-1:0]   wk_sum_r;
  logic [NUMW-1:0]   num_r;

  logic [MW-1:0]     tot_mem [WINDOW_DEPTH];
  logic [MW-1:0]     dev_mem [NUM_DEVICES * WINDOW_DEPTH];
  logic [MW-1:0]     tot_rd_r, dev_rd_r, rd_word;
  time_t             rd_time;
  logic [CNT_W-1:0]  rd_cnt;

  logic              out_vld_r;
  logic [RATE_W-1:0] out_tot_r, out_dev_r, tot_rate_r, dev_rate_r;
  logic              out_due_r, out_ovf_r;

  logic [7:0]        d_ext;
  logic [DEVW-1:0]   dev_idx;
  logic              dev_ok;
  logic [DAW-1:0]    dev_base;
  logic [FW:0]       slot_sum;
  logic [HW-1:0]     slot, head_inc;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_p;
  logic [MUL_PW+CNT_W-1:0] mul_hi_sh;
  time_t             rd_span;
  logic              div_done;
  logic [RATE_W-1:0] div_rate;

  assign d_ext    = {6'd0, d_r};
  assign dev_idx  = d_ext[DEVW-1:0];
  assign dev_ok   = d_ext < 8'(NUM_DEVICES);
  assign dev_base = DAW'(dev_idx * WINDOW_DEPTH);

  assign slot_sum = (FW+1)'(wk_head_r) + (FW+1)'(wk_fill_r);
  assign slot     = (slot_sum >= (FW+1)'(WINDOW_DEPTH))
                    ? HW'(slot_sum - (FW+1)'(WINDOW_DEPTH)) : HW'(slot_sum);
  assign head_inc = (wk_head_r == HW'(WINDOW_DEPTH - 1)) ? '0 : wk_head_r + 1'b1;

  assign rd_word  = sel_r ? dev_rd_r : tot_rd_r;
  assign rd_time  = rd_word[MW-1:CNT_W];
  assign rd_cnt   = rd_word[CNT_W-1:0];
  assign rd_span  = span_of(rd_time, t_r);

  always_comb begin
    unique case (state_r)
      S_THR1:  mul_a = {1'b0, window_ms_r} + 1'b1;
      S_THR2:  mul_a = {1'b0, print_ms_r} + 1'b1;
      S_MLO:   mul_a = {1'b0, wk_sum_r[CNT_W-1:0]};
      default: mul_a = {{(MUL_AW+CNT_W-SUMW){1'b0}}, wk_sum_r[SUMW-1:CNT_W]};
    endcase
    mul_b = (state_r == S_THR1 || state_r == S_THR2) ? NS_PER_MS : NS_PER_S;
  end
  assign mul_p     = mul_a * mul_b;
  assign mul_hi_sh = {mul_p, {CNT_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (state_r == S_WRT && !sel_r) begin
      tot_mem[slot] <= {t_r, c_r};
    end
    if (state_r == S_WRT && sel_r) begin
      dev_mem[DAW'(dev_base + DAW'(slot))] <= {t_r, c_r};
    end
    tot_rd_r <= tot_mem[wk_head_r];
    dev_rd_r <= dev_mem[DAW'(dev_base + DAW'(wk_head_r))];
  end

  twm_rate_div #(.NUMW(NUMW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DST),
    .num   (num_r),
    .den   (span_r),
    .done  (div_done),
    .rate  (div_rate)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      print_ms_r   <= RST_PRINT_INTERVAL;
      window_ms_r  <= RST_WINDOW;
      last_print_r <= '0;
      tot_head_r   <= '0;
      tot_fill_r   <= '0;
      tot_sum_r    <= '0;
      dev_vld_r    <= '0;
      out_vld_r    <= 1'b0;
      sel_r        <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2] == REG_PRINT_INTERVAL) begin
          print_ms_r <= pwdata;
        end else begin
          window_ms_r <= pwdata;
        end
      end
      if (state_r == S_OUT && (!out_vld_r || out_beat.ready)) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && out_beat.ready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_beat.valid) begin
            t_r     <= in_beat.time_ns;
            c_r     <= in_beat.work_count;
            d_r     <= in_beat.device_index;
            ovf_r   <= 1'b0;
            sel_r   <= 1'b0;
            state_r <= S_THR1;
          end
        end
        S_THR1: begin
          wthr_r  <= mul_p;
          state_r <= S_THR2;
        end
        S_THR2: begin
          pthr_r  <= mul_p;
          state_r <= S_DUE;
        end
        S_DUE: begin
          due_r <= span_of(last_print_r, t_r) >= pthr_r;
          if (span_of(last_print_r, t_r) >= pthr_r) begin
            last_print_r <= t_r;
          end
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          if (!sel_r) begin
            wk_head_r <= tot_head_r;
            wk_fill_r <= tot_fill_r;
            wk_sum_r  <= tot_sum_r;
          end else if (dev_vld_r[dev_idx]) begin
            wk_head_r <= dev_head_r[dev_idx];
            wk_fill_r <= dev_fill_r[dev_idx];
            wk_sum_r  <= dev_sum_r[dev_idx];
          end else begin
            wk_head_r <= '0;
            wk_fill_r <= '0;
            wk_sum_r  <= '0;
          end
          state_r <= S_CHKF;
        end
        S_CHKF: begin
          state_r <= (wk_fill_r == FW'(WINDOW_DEPTH)) ? S_OVF : S_WRT;
        end
        S_OVF: begin
          if (!(rd_span >= wthr_r)) begin
            ovf_r <= 1'b1;
          end
          wk_sum_r  <= wk_sum_r - SUMW'(rd_cnt);
          wk_head_r <= head_inc;
          wk_fill_r <= wk_fill_r - 1'b1;
          state_r   <= S_WRT;
        end
        S_WRT: begin
          wk_fill_r <= wk_fill_r + 1'b1;
          wk_sum_r  <= wk_sum_r + SUMW'(c_r);
          state_r   <= S_PREQ;
        end
        S_PREQ: begin
          state_r <= S_PCHK;
        end
        S_PCHK: begin
          if (wk_fill_r > FW'(MIN_KEPT) && rd_span >= wthr_r) begin
            wk_sum_r  <= wk_sum_r - SUMW'(rd_cnt);
            wk_head_r <= head_inc;
            wk_fill_r <= wk_fill_r - 1'b1;
            state_r   <= S_PREQ;
          end else begin
            span_r <= rd_span;
            if (!sel_r) begin
              tot_head_r <= wk_head_r;
              tot_fill_r <= wk_fill_r;
              tot_sum_r  <= wk_sum_r;
            end else begin
              dev_head_r[dev_idx] <= wk_head_r;
              dev_fill_r[dev_idx] <= wk_fill_r;
              dev_sum_r[dev_idx]  <= wk_sum_r;
              dev_vld_r[dev_idx]  <= 1'b1;
            end
            state_r <= S_MLO;
          end
        end
        S_MLO: begin
          num_r   <= NUMW'(mul_p);
          state_r <= S_MHI;
        end
        S_MHI: begin
          num_r   <= num_r + mul_hi_sh[NUMW-1:0];
          state_r <= S_DST;
        end
        S_DST: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (sel_r) begin
              dev_rate_r <= div_rate;
              state_r    <= S_OUT;
            end else begin
              tot_rate_r <= div_rate;
              if (dev_ok) begin
                sel_r   <= 1'b1;
                state_r <= S_LOAD;
              end else begin
                dev_rate_r <= '0;
                state_r    <= S_OUT;
              end
            end
          end
        end
        S_OUT: begin
          if (!out_vld_r || out_beat.ready) begin
            out_tot_r <= tot_rate_r;
            out_dev_r <= dev_rate_r;
            out_due_r <= due_r;
            out_ovf_r <= ovf_r;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_beat.ready          = (state_r == S_IDLE);
  assign out_beat.valid         = out_vld_r;
  assign out_beat.total_rate    = out_tot_r;
  assign out_beat.device_rate   = out_dev_r;
  assign out_beat.print_due     = out_due_r;
  assign out_beat.ring_overflow = out_ovf_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WINDOW) ? window_ms_r : print_ms_r;
endmodule
`default_nettype wire

// File: dv/windowed_throughput_meter_core_tb.sv
// Self-checking testbench for windowed_throughput_meter_core with a built-in rate predictor.
`timescale 1ns / 1ps
module windowed_throughput_meter_core_tb;
  import twm_pkg::*;

  localparam int DEPTH = 64;
  localparam int NDEV = 4;
  localparam int TOT = NDEV;
  localparam int SETTLE = 600;
  localparam longint unsigned LIMIT = 6000000;
  localparam logic [62:0] STAMP_MAX = {63{1'b1}};

  typedef struct packed {
    logic [RATE_W-1:0] total_rate;
    logic [RATE_W-1:0] device_rate;
    logic print_due;
    logic ring_overflow;
  } rate_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [CFG_W-1:0] pwdata = '0;
  logic [CFG_W-1:0] prdata;
  logic pready;

  twm_in_if in_ch();
  twm_out_if out_ch();

  windowed_throughput_meter_core dut (
    .clk(clk), .rst_n(rst_n), .in_beat(in_ch), .out_beat(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [62:0] ring_stamp [NDEV+1][DEPTH];
  logic [31:0] ring_work [NDEV+1][DEPTH];
  int unsigned ring_head [NDEV+1];
  int unsigned ring_fill [NDEV+1];
  logic [63:0] ring_sum [NDEV+1];
  logic [31:0] print_interval_ms;
  logic [31:0] window_ms;
  logic [62:0] last_print;

  rate_report_t pending_reports[$];
  int errors = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int overflow_seen = 0;
  int due_seen = 0;
  int sat_seen = 0;
  bit no_idle = 1'b0;
  longint unsigned cycles = 0;
  logic [62:0] stamp_now = '0;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("windowed_throughput_meter_core regression: fail");
      $finish;
    end
  end

  function automatic logic [62:0] span_ns(logic [62:0] older, logic [62:0] newer);
    return (newer >= older) ? newer - older : '0;
  endfunction

  function automatic void drop_oldest(int r);
    ring_sum[r] = ring_sum[r] - ring_work[r][ring_head[r]];
    ring_head[r] = (ring_head[r] + 1) % DEPTH;
    ring_fill[r]--;
  endfunction

  function automatic logic [62:0] ring_span(int r);
    return span_ns(ring_stamp[r][ring_head[r]],
                   ring_stamp[r][(ring_head[r] + ring_fill[r] - 1) % DEPTH]);
  endfunction

  function automatic bit push_sample(int r, logic [62:0] stamp, logic [31:0] work);
    bit ovf = 1'b0;
    if (ring_fill[r] >= DEPTH) begin
      ovf = !((span_ns(ring_stamp[r][ring_head[r]], stamp) / 1000000) > window_ms);
      drop_oldest(r);
    end
    ring_stamp[r][(ring_head[r] + ring_fill[r]) % DEPTH] = stamp;
    ring_work[r][(ring_head[r] + ring_fill[r]) % DEPTH] = work;
    ring_fill[r]++;
    ring_sum[r] = ring_sum[r] + work;
    while (ring_fill[r] > MIN_KEPT && (ring_span(r) / 1000000) > window_ms)
      drop_oldest(r);
    return ovf;
  endfunction

  function automatic logic [RATE_W-1:0] ring_rate(int r);
    logic [127:0] num;
    logic [127:0] quo;
    logic [62:0] span;
    if (ring_fill[r] == 0) return '0;
    span = ring_span(r);
    if (span == 0) return '0;
    num = 128'(ring_sum[r]) * 128'd1000000000;
    quo = num / 128'(span);
    return (quo > 128'(RATE_MAX)) ? RATE_MAX : quo[RATE_W-1:0];
  endfunction

  function automatic rate_report_t predict_report(logic [62:0] stamp, logic [31:0] work,
                                                  logic [1:0] dev);
    rate_report_t rep;
    rep.print_due = (span_ns(last_print, stamp) / 1000000) > print_interval_ms;
    rep.ring_overflow = push_sample(TOT, stamp, work);
    if (push_sample(int'(dev), stamp, work)) rep.ring_overflow = 1'b1;
    rep.device_rate = ring_rate(int'(dev));
    if (rep.print_due) last_print = stamp;
    rep.total_rate = ring_rate(TOT);
    return rep;
  endfunction

  task automatic send_report(logic [62:0] stamp, logic [31:0] work, logic [1:0] dev);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.time_ns <= stamp;
    in_ch.work_count <= work;
    in_ch.device_index <= dev;
    do @(posedge clk); while (!in_ch.ready);
    pending_reports.insert(pending_reports.size(), predict_report(stamp, work, dev));
    beats_sent++;
  endtask

  task automatic write_reg(int idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == int'(REG_PRINT_INTERVAL)) print_interval_ms = value;
    else window_ms = value;
  endtask

  task automatic drain_and_configure(logic [31:0] interval, logic [31:0] window);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    write_reg(int'(REG_PRINT_INTERVAL), interval);
    write_reg(int'(REG_WINDOW), window);
  endtask

  // Output side: draws a stall per beat and checks every accepted result.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  always @(posedge clk) begin
    rate_report_t exp_rep;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_checked++;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected", $time);
      end else begin
        exp_rep = pending_reports[0];
        pending_reports.delete(0);
        if (exp_rep.ring_overflow) overflow_seen++;
        if (exp_rep.print_due) due_seen++;
        if (exp_rep.total_rate == RATE_MAX) sat_seen++;
        if (out_ch.total_rate !== exp_rep.total_rate) begin
          errors++;
          $display("%0t: total_rate expected %0d actual %0d", $time,
                   exp_rep.total_rate, out_ch.total_rate);
        end
        if (out_ch.device_rate !== exp_rep.device_rate) begin
          errors++;
          $display("%0t: device_rate expected %0d actual %0d", $time,
                   exp_rep.device_rate, out_ch.device_rate);
        end
        if (out_ch.print_due !== exp_rep.print_due) begin
          errors++;
          $display("%0t: print_due expected %0b actual %0b", $time,
                   exp_rep.print_due, out_ch.print_due);
        end
        if (out_ch.ring_overflow !== exp_rep.ring_overflow) begin
          errors++;
          $display("%0t: ring_overflow expected %0b actual %0b", $time,
                   exp_rep.ring_overflow, out_ch.ring_overflow);
        end
      end
    end
  end

  task automatic test_extremes();
    send_report(63'd0, 32'hFFFF_FFFF, 2'd0);
    send_report(63'd1, 32'hFFFF_FFFF, 2'd0);
    send_report(63'd1, 32'd0, 2'd1);
    send_report(63'd2_000_000_000, 32'd5, 2'd2);
    send_report(63'd1_000_000_000, 32'd7, 2'd2);
    send_report(63'd30_000_000_000, 32'hAAAA_5555, 2'd3);
    send_report(STAMP_MAX - 63'd5_000_000_000, 32'h5555_AAAA, 2'd1);
    send_report(STAMP_MAX, 32'd1, 2'd3);
    send_report(STAMP_MAX, 32'hFFFF_FFFF, 2'd0);
    send_report(63'd100, 32'd3, 2'd2);
  endtask

  task automatic test_overflow();
    stamp_now = 63'd1_000_000;
    for (int i = 0; i < 70; i++) begin
      send_report(stamp_now, $urandom, 2'(i % 2));
      stamp_now = stamp_now + 63'd1_000_000;
    end
  endtask

  task automatic test_random(int count, int max_step_ms);
    logic [62:0] step;
    int kind;
    stamp_now = {$urandom_range(0, 1) ? 31'($urandom) : 31'd0, $urandom};
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 3) step = '0;
      else if (kind < 85) step = 63'($urandom_range(0, max_step_ms)) * 63'd1_000_000
                                 + 63'($urandom_range(0, 999_999));
      else if (kind < 92) step = 63'($urandom_range(0, 50));
      else step = {31'($urandom_range(0, 3)), $urandom};
      if (kind >= 97 || STAMP_MAX - stamp_now < step)
        stamp_now = stamp_now - 63'(64'($urandom_range(0, 1_000_000_000))
                                    % (64'(stamp_now) + 64'd1));
      else stamp_now = stamp_now + step;
      send_report(stamp_now,
                  ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : 32'($urandom),
                  2'($urandom_range(0, 3)));
      if (i % 200 == 199) no_idle = ~no_idle;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    for (int r = 0; r <= NDEV; r++) begin
      ring_head[r] = 0;
      ring_fill[r] = 0;
      ring_sum[r] = '0;
    end
    print_interval_ms = RST_PRINT_INTERVAL;
    window_ms = RST_WINDOW;
    last_print = '0;
    in_ch.valid = 1'b0;
    in_ch.time_ns = '0;
    in_ch.work_count = '0;
    in_ch.device_index = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_overflow();
    test_random(450, 40);
    drain_and_configure(32'd0, 32'd0);
    test_random(400, 5);
    drain_and_configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    test_overflow();
    test_random(400, 2000);
    drain_and_configure(32'($urandom_range(1, 200)), 32'($urandom_range(1, 50)));
    test_random(400, 20);
    drain_and_configure(32'd500, 32'd3);
    test_random(350, 2);

    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d reports and checked %0d results over five register settings.",
             beats_sent, beats_checked);
    $display("Results with overflow %0d, print due %0d, saturated total rate %0d.",
             overflow_seen, due_seen, sat_seen);
    if (errors == 0) begin
      $display("windowed_throughput_meter_core regression: pass");
    end else begin
      $display("windowed_throughput_meter_core regression: fail");
    end
    $finish;
  end
endmodule
